// ===== hw/rtl/lehmer_random_range_generator_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the Lehmer random range generator
// Each macro expands to a labeled concurrent assertion in simulation and to
// nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef LEHMER_RANDOM_RANGE_GENERATOR_CORE_MACROS_SVH
`define LEHMER_RANDOM_RANGE_GENERATOR_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define LRG_ASSERT_IMPL(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error(msg);
`define LRG_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error(msg);
`else
`define LRG_ASSERT_IMPL(lbl, clk_s, rstn_s, ante, cons, msg)
`define LRG_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg)
`endif

`endif

// ===== hw/rtl/lrg_pkg.sv =====
// ----------------------------------------------------------------------------
// lrg_pkg
// Types and constants shared by the Lehmer generator controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package lrg_pkg;

  localparam int unsigned StateW = 31;
  localparam int unsigned DivW   = 20;
  localparam int unsigned CntW   = 5;

  localparam logic [StateW-1:0] DRAW_MAX = 31'h7FFF_FFFE;
  localparam logic [15:0]       MULT     = 16'd48271;
  localparam logic [DivW-1:0]   PCT_SPAN = 20'd100;
  localparam logic [CntW-1:0]   DIV_LAST = 5'd30;

  // Span limits expressed on span - 1.
  localparam logic [32:0] TOP_MAX   = 33'd2147483645;
  localparam logic [32:0] SMALL_TOP = 33'd1048574;

  localparam logic [1:0] KIND_RAW    = 2'd0;
  localparam logic [1:0] KIND_CHOICE = 2'd1;
  localparam logic [1:0] KIND_PCT    = 2'd2;

  typedef struct packed {
    logic load_req;
    logic calc_mask;
    logic mul;
    logic fold;
    logic div_step;
    logic load_out;
  } lrg_cmd_t;

  typedef struct packed {
    logic err;
    logic raw;
    logic small_span;
    logic reject;
    logic div_done;
  } lrg_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lrg_datapath.sv =====
// ----------------------------------------------------------------------------
// lrg_datapath
// Generator state, multiply and fold, serial remainder, mask test and the
// result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module lrg_datapath
  import lrg_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_wr_en,
  input  wire logic [31:0]        cfg_wr_data,
  input  wire logic [1:0]         req_kind,
  input  wire logic [31:0]        req_low,
  input  wire logic [31:0]        req_high,
  input  wire logic [6:0]         req_pct,
  input  wire lrg_cmd_t           cmd,
  output lrg_status_t             status,
  output logic [31:0]             res_value,
  output logic                    res_truth,
  output logic                    res_error
);

  logic [StateW-1:0] x_r, x_nxt;
  logic [46:0]       z_r;
  logic [31:0]       lo_r;
  logic [StateW-1:0] top_r;
  logic [StateW-1:0] mask_r;
  logic [DivW-1:0]   div_r;
  logic [DivW-1:0]   rem_r;
  logic [StateW-1:0] div_sh_r;
  logic [CntW-1:0]   cnt_r;
  logic [6:0]        pct_r;
  logic              err_r, raw_r, pct_sel_r, small_r;

  logic signed [33:0] sd, sd_m, sd_p1, sd_p2, sd_r;
  logic [StateW-1:0]  seed_fold;
  logic [31:0]        fold_sum;
  logic [StateW-1:0]  fold_val;
  logic [32:0]        diff;
  logic               range_bad;
  logic [StateW-1:0]  mask_c;
  logic [DivW:0]      rem_sh;
  logic [StateW-1:0]  masked;
  logic [6:0]         pct_val;

  // Seed fold into 1..DRAW_MAX: at most two additions of DRAW_MAX are
  // needed for a negative seed, at most one subtraction for a positive one.
  always_comb begin
    sd    = 34'($signed(cfg_wr_data)) - 34'sd1;
    sd_m  = sd - $signed({3'b000, DRAW_MAX});
    sd_p1 = sd + $signed({3'b000, DRAW_MAX});
    sd_p2 = sd_p1 + $signed({3'b000, DRAW_MAX});
    if (!sd[33] && !sd_m[33]) begin
      sd_r = sd_m;
    end else if (!sd[33]) begin
      sd_r = sd;
    end else if (!sd_p1[33]) begin
      sd_r = sd_p1;
    end else begin
      sd_r = sd_p2;
    end
    seed_fold = sd_r[30:0] + 31'd1;
  end

  // Mersenne fold of the 47-bit product.
  always_comb begin
    fold_sum = {1'b0, z_r[30:0]} + {16'b0, z_r[46:31]};
    fold_val = fold_sum[31] ? (fold_sum[30:0] + 31'd1) : fold_sum[30:0];
  end

  always_comb begin
    diff      = {req_high[31], req_high} - {req_low[31], req_low};
    range_bad = diff[32] || (diff > TOP_MAX);
  end

  always_comb begin
    mask_c = top_r;
    mask_c = mask_c | (mask_c >> 1);
    mask_c = mask_c | (mask_c >> 2);
    mask_c = mask_c | (mask_c >> 4);
    mask_c = mask_c | (mask_c >> 8);
    mask_c = mask_c | (mask_c >> 16);
  end

  assign rem_sh  = {rem_r, div_sh_r[StateW-1]};
  assign masked  = x_r & mask_r;
  assign pct_val = rem_r[6:0] + 7'd1;

  always_comb begin
    x_nxt = x_r;
    if (cfg_wr_en) begin
      x_nxt = seed_fold;
    end else if (cmd.fold) begin
      x_nxt = fold_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r <= 31'd1;
    end else begin
      x_r <= x_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      lo_r      <= req_low;
      top_r     <= diff[30:0];
      pct_r     <= req_pct;
      raw_r     <= (req_kind == KIND_RAW);
      pct_sel_r <= (req_kind == KIND_PCT);
      err_r     <= ((req_kind == KIND_CHOICE) && range_bad) ||
                   ((req_kind != KIND_RAW) && (req_kind != KIND_CHOICE) &&
                    (req_kind != KIND_PCT));
      small_r   <= (req_kind == KIND_PCT) || (diff <= SMALL_TOP);
      div_r     <= (req_kind == KIND_PCT) ? PCT_SPAN : diff[DivW-1:0] + 20'd1;
    end
    if (cmd.calc_mask) begin
      mask_r <= mask_c;
    end
    if (cmd.mul) begin
      z_r <= 47'(x_r) * 47'(MULT);
    end
    if (cmd.fold) begin
      div_sh_r <= fold_val;
      rem_r    <= '0;
      cnt_r    <= '0;
    end else if (cmd.div_step) begin
      div_sh_r <= div_sh_r << 1;
      rem_r    <= (rem_sh >= {1'b0, div_r}) ? DivW'(rem_sh - {1'b0, div_r})
                                            : rem_sh[DivW-1:0];
      cnt_r    <= cnt_r + 5'd1;
    end
    if (cmd.load_out) begin
      if (err_r) begin
        res_value <= '0;
        res_truth <= 1'b0;
        res_error <= 1'b1;
      end else if (raw_r) begin
        res_value <= {1'b0, x_r};
        res_truth <= 1'b0;
        res_error <= 1'b0;
      end else if (pct_sel_r) begin
        res_value <= {25'b0, pct_val};
        res_truth <= (pct_val <= pct_r);
        res_error <= 1'b0;
      end else if (small_r) begin
        res_value <= lo_r + {12'b0, rem_r};
        res_truth <= 1'b0;
        res_error <= 1'b0;
      end else begin
        res_value <= lo_r + {1'b0, masked};
        res_truth <= 1'b0;
        res_error <= 1'b0;
      end
    end
  end

  always_comb begin
    status.err        = err_r;
    status.raw        = raw_r;
    status.small_span = small_r;
    status.reject     = (masked > top_r);
    status.div_done   = (cnt_r == DIV_LAST);
  end

endmodule

`default_nettype wire

// ===== hw/rtl/lrg_ctrl.sv =====
// ----------------------------------------------------------------------------
// lrg_ctrl
// Sequencer for one request: decode, draw, remainder or rejection, result.
// ----------------------------------------------------------------------------
`default_nettype none

module lrg_ctrl
  import lrg_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  input  wire lrg_status_t status,
  output lrg_cmd_t         cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_MUL,
    ST_FOLD,
    ST_DIV,
    ST_CHECK,
    ST_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free  = !out_valid_r || out_tready;
  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load_req = 1'b1;
          state_nxt    = ST_DECODE;
        end
      end
      ST_DECODE: begin
        cmd.calc_mask = 1'b1;
        state_nxt     = status.err ? ST_DONE : ST_MUL;
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_FOLD;
      end
      ST_FOLD: begin
        cmd.fold = 1'b1;
        if (status.raw) begin
          state_nxt = ST_DONE;
        end else if (status.small_span) begin
          state_nxt = ST_DIV;
        end else begin
          state_nxt = ST_CHECK;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_CHECK: begin
        state_nxt = status.reject ? ST_MUL : ST_DONE;
      end
      ST_DONE: begin
        if (slot_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/lehmer_random_range_generator_core.sv =====
// ----------------------------------------------------------------------------
// lehmer_random_range_generator_core
// Park-Miller generator (multiplier 48271) with raw draws, range choices and
// percent tests.
// ----------------------------------------------------------------------------
//  Channel | Direction | tdata (low bit up)               | tuser
//  in_     | slave     | range_low, range_high, percent   | kind
//  out_    | master    | value, truth                     | error
//  cfg_    | write     | seed (cfg_wr_data)               | -
//
// A raw draw runs from accept to out_tvalid through decode, the multiply and
// the fold on the shared 31x16 multiplier path, and the result load. A
// small-span choice or a percent test adds the bit-serial remainder unit
// after the fold. A large-span choice repeats multiply, fold and check for
// each rejected draw. A refused request goes from decode to the result load.
// Synchronous active-low reset loads the state with 1; a held result stalls
// only the finish of the next request, not its acceptance.
// ----------------------------------------------------------------------------
`default_nettype none
`include "lehmer_random_range_generator_core_macros.svh"

module lehmer_random_range_generator_core
  import lrg_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [31:0] cfg_wr_data,   // seed
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [71:0] in_tdata,      // range_low, range_high, percent, zero pad
  input  wire logic [1:0]  in_tuser,      // kind
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,     // value, truth, zero pad
  output logic             out_tuser      // error
);

  lrg_cmd_t    cmd;
  lrg_status_t status;
  logic [31:0] res_value;
  logic        res_truth;
  logic        res_error;

  lrg_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  lrg_datapath u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .req_kind    (in_tuser),
    .req_low     (in_tdata[31:0]),
    .req_high    (in_tdata[63:32]),
    .req_pct     (in_tdata[70:64]),
    .cmd         (cmd),
    .status      (status),
    .res_value   (res_value),
    .res_truth   (res_truth),
    .res_error   (res_error)
  );

  assign out_tdata = {7'b0, res_truth, res_value};
  assign out_tuser = res_error;

  `LRG_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_tvalid && in_tready, !in_tready, "ready after accept")
  `LRG_ASSERT_IMPL(a_error_zero, clk, rst_n, out_tvalid && out_tuser, out_tdata == 40'd0, "refused word carries data")
  `LRG_ASSERT_IMPL(a_truth_range, clk, rst_n, out_tvalid && out_tdata[32], (out_tdata[31:7] == 25'd0) && (out_tdata[6:0] != 7'd0), "truth with bad draw")
  `LRG_ASSERT_IMPL(a_one_cmd, clk, rst_n, 1'b1, $onehot0({cmd.load_req, cmd.calc_mask, cmd.mul, cmd.fold, cmd.div_step, cmd.load_out}), "overlapping commands")

endmodule

`default_nettype wire
